// File: sv/sbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_RET  = 3'd1;
  localparam logic [2:0] CMD_NEG  = 3'd2;
  localparam logic [2:0] CMD_ADD  = 3'd3;
  localparam logic [2:0] CMD_SUB  = 3'd4;
  localparam logic [2:0] CMD_MUL  = 3'd5;
  localparam logic [2:0] CMD_DIV  = 3'd6;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RET   = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;
  localparam logic [2:0] ST_DIV0  = 3'd5;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic commit;
  } sbe_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic mul_done;
    logic div_done;
  } sbe_stat_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] signed_from_mag(input logic neg, input logic [63:0] m,
                                                  input logic too_big);
    if (neg) begin
      signed_from_mag = (too_big || m > SIGN_BIT) ? SIGN_BIT : (~m + 64'd1);
    end else begin
      signed_from_mag = (too_big || m > MAX_POS) ? MAX_POS : m;
    end
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) sat_add = a[63] ? SIGN_BIT : MAX_POS;
    else sat_add = r;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) sat_sub = a[63] ? SIGN_BIT : MAX_POS;
    else sat_sub = r;
  endfunction

  function automatic logic [63:0] sat_neg(input logic [63:0] a);
    sat_neg = (a == SIGN_BIT) ? MAX_POS : (~a + 64'd1);
  endfunction

endpackage
`default_nettype wire

// File: sv/sbe_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sbe_div
  import sbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quo_lo,
  output logic             quo_hi_nz
);

  // Restoring division of {dividend, 32 zero bits}, one quotient bit per cycle.
  // Quotient bits shift into the low end of the dividend register.
  logic [127:0] num;
  logic [63:0]  rem;
  logic [63:0]  dvs;
  logic [7:0]   cnt;
  logic [64:0]  rs;
  logic [64:0]  diff;

  assign rs   = {rem, num[127]};
  assign diff = rs - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 8'd0;
    end else if (start) begin
      cnt <= 8'd128;
    end else if (cnt != 8'd0) begin
      cnt <= cnt - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {dividend, 64'd0} >> 32;
      rem <= 64'd0;
      dvs <= divisor;
    end else if (cnt != 8'd0) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        num <= {num[126:0], 1'b1};
      end else begin
        rem <= rs[63:0];
        num <= {num[126:0], 1'b0};
      end
    end
  end

  assign done      = (cnt == 8'd0);
  assign quo_lo    = num[63:0];
  assign quo_hi_nz = |num[127:64];

endmodule
`default_nettype wire

// File: sv/sbe_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sbe_dp
  import sbe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sbe_cmd_t           cmd_bus,
  output sbe_stat_t               stat,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [63:0]        in_const,
  output logic [2:0]              out_status,
  output logic [63:0]             out_value,
  output logic [DEPTH_W-1:0]      out_depth
);

  // The top of stack lives in top_q; the memory holds the entries below it.
  logic [63:0]         mem [STACK_DEPTH];
  logic [63:0]         rd_data;
  logic [63:0]         top_q;
  logic [63:0]         cval_q;
  logic [2:0]          op_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [DEPTH_W-1:0]  dm1;
  logic [DEPTH_W-1:0]  dm2;
  logic                err;
  logic                div_zero;
  logic                wr_en;

  logic [63:0]  mx, my, prod;
  logic [127:0] acc;
  logic [2:0]   mcnt;

  logic         dv_done, dv_hi_nz;
  logic [63:0]  dv_lo;

  logic [2:0]          res_status;
  logic [63:0]         res_value;
  logic [63:0]         top_next;
  logic [DEPTH_W-1:0]  depth_next;
  logic [63:0]         top_or_zero;
  logic [63:0]         bin_r;

  assign dm1 = depth_q - DEPTH_W'(1);
  assign dm2 = depth_q - DEPTH_W'(2);
  assign top_or_zero = (depth_q == '0) ? 64'd0 : top_q;

  always_comb begin
    unique case (op_q)
      CMD_PUSH:               err = (depth_q == DEPTH_W'(STACK_DEPTH));
      CMD_RET, CMD_NEG:       err = (depth_q == '0);
      CMD_ADD, CMD_SUB,
      CMD_MUL, CMD_DIV:       err = (depth_q < DEPTH_W'(2));
      default:                err = 1'b1;
    endcase
  end

  assign div_zero = (op_q == CMD_DIV) && (top_q == 64'd0);
  assign wr_en    = cmd_bus.commit && (op_q == CMD_PUSH) && !err && (depth_q != '0);

  always_ff @(posedge clk) begin
    if (cmd_bus.load) rd_data <= mem[dm2[ADDR_W-1:0]];
    if (wr_en) mem[dm1[ADDR_W-1:0]] <= top_q;
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.load) begin
      op_q   <= in_cmd;
      cval_q <= in_const;
    end
  end

  // Multiplier: four 32x32 partial products through one shared unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= 3'd0;
    end else if (cmd_bus.mul_start) begin
      mcnt <= 3'd0;
    end else if (cmd_bus.mul_step) begin
      mcnt <= mcnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.mul_start) begin
      mx  <= mag(rd_data);
      my  <= mag(top_q);
      acc <= 128'd0;
    end else if (cmd_bus.mul_step) begin
      unique case (mcnt)
        3'd0: prod <= mx[31:0] * my[31:0];
        3'd1: prod <= mx[31:0] * my[63:32];
        3'd2: prod <= mx[63:32] * my[31:0];
        3'd3: prod <= mx[63:32] * my[63:32];
        default: prod <= prod;
      endcase
      unique case (mcnt)
        3'd1: acc <= acc + {64'd0, prod};
        3'd2, 3'd3: acc <= acc + {32'd0, prod, 32'd0};
        3'd4: acc <= acc + {prod, 64'd0};
        default: acc <= acc;
      endcase
    end
  end

  sbe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd_bus.div_start),
    .dividend  (mag(rd_data)),
    .divisor   (mag(top_q)),
    .done      (dv_done),
    .quo_lo    (dv_lo),
    .quo_hi_nz (dv_hi_nz)
  );

  assign stat.is_mul   = (op_q == CMD_MUL) && !err;
  assign stat.is_div   = (op_q == CMD_DIV) && !err && !div_zero;
  assign stat.mul_done = (mcnt == 3'd5);
  assign stat.div_done = dv_done;

  always_comb begin
    unique case (op_q)
      CMD_ADD: bin_r = sat_add(rd_data, top_q);
      CMD_SUB: bin_r = sat_sub(rd_data, top_q);
      CMD_MUL: bin_r = signed_from_mag(rd_data[63] ^ top_q[63], acc[95:32], |acc[127:96]);
      default: begin
        if (div_zero) begin
          bin_r = (rd_data == 64'd0) ? 64'd0 : (rd_data[63] ? SIGN_BIT : MAX_POS);
        end else begin
          bin_r = signed_from_mag(rd_data[63] ^ top_q[63], dv_lo, dv_hi_nz);
        end
      end
    endcase
  end

  always_comb begin
    top_next   = top_q;
    depth_next = depth_q;
    res_value  = top_or_zero;
    res_status = ST_OK;
    if (err) begin
      unique case (op_q)
        CMD_PUSH: res_status = ST_OVER;
        CMD_RET, CMD_NEG, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: res_status = ST_UNDER;
        default:  res_status = ST_BAD;
      endcase
    end else begin
      unique case (op_q)
        CMD_PUSH: begin
          top_next   = cval_q;
          depth_next = depth_q + DEPTH_W'(1);
          res_value  = cval_q;
        end
        CMD_RET: begin
          top_next   = rd_data;
          depth_next = dm1;
          res_status = ST_RET;
        end
        CMD_NEG: begin
          top_next  = sat_neg(top_q);
          res_value = top_next;
        end
        default: begin
          top_next   = bin_r;
          depth_next = dm1;
          res_value  = bin_r;
          res_status = div_zero ? ST_DIV0 : ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_q <= '0;
    end else if (cmd_bus.commit) begin
      depth_q <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.commit) begin
      top_q      <= top_next;
      out_status <= res_status;
      out_value  <= res_value;
      out_depth  <= depth_next;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.commit && op_q == CMD_PUSH && !err |=> depth_q == $past(depth_q) + DEPTH_W'(1))
    else $error("successful push did not grow the stack");

  a_err_keeps: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.commit && err |=> depth_q == $past(depth_q))
    else $error("failed instruction changed the stack depth");
`endif

endmodule
`default_nettype wire

// File: sv/sbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sbe_ctrl
  import sbe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire sbe_stat_t stat,
  output sbe_cmd_t       cmd_bus
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cmd_bus    = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_bus.load = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        if (stat.is_mul) begin
          cmd_bus.mul_start = 1'b1;
          state_next        = S_MUL;
        end else if (stat.is_div) begin
          cmd_bus.div_start = 1'b1;
          state_next        = S_DIV;
        end else begin
          cmd_bus.commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_MUL: begin
        if (stat.mul_done) begin
          cmd_bus.commit = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd_bus.mul_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd_bus.commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd_bus.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/stack_bytecode_evaluator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: push, return, negate, add, subtract, error and divide-by-zero cases pass
// from the request through the read state to the result register; multiply adds a step
// state (four partial products on one 32x32 multiplier); divide adds a wait on the
// restoring divider, one quotient bit per cycle over 128 bits.
// Flow: one request at a time; the next can be taken in the cycle the result is taken.
// Reset: synchronous active-high rst empties the stack and clears all handshake state;
// stack memory contents are not cleared.
module stack_bytecode_evaluator_top
  import sbe_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [63:0] const_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic signed [63:0]      value,
  output logic [8:0]              depth
);

  // The controller sequences each request; the datapath holds the stack,
  // the arithmetic units and the result register.
  sbe_cmd_t     cmd_bus;
  sbe_stat_t    stat;
  logic [63:0]  value_u;

  sbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd_bus   (cmd_bus)
  );

  sbe_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd_bus    (cmd_bus),
    .stat       (stat),
    .in_cmd     (cmd),
    .in_const   (const_value),
    .out_status (status),
    .out_value  (value_u),
    .out_depth  (depth)
  );

  // The result register holds plain bits; the port carries them as signed Q32.32.
  assign value = signed'(value_u);

endmodule
`default_nettype wire
